### rtl/scfp_pkg.sv
`default_nettype none

package scfp_pkg;

    localparam int MAX_TOKENS_DEF = 4;
    localparam int VALUE_BITS_DEF = 32;
    localparam int VALUE_W        = 32;
    localparam int QUEUE_DEPTH    = 2;

    localparam int REG_W  = 32;
    localparam int ADDR_W = 4;

    typedef logic [3:0] status_t;

    localparam status_t ST_OK          = 4'd0;
    localparam status_t ST_TOO_LARGE   = 4'd1;
    localparam status_t ST_BAD_OPCODE  = 4'd2;
    localparam status_t ST_NO_TERM     = 4'd3;
    localparam status_t ST_EMBED_NUL   = 4'd4;
    localparam status_t ST_CONTROL     = 4'd5;
    localparam status_t ST_INJECTION   = 4'd6;
    localparam status_t ST_UNSUPPORTED = 4'd7;
    localparam status_t ST_ARG_COUNT   = 4'd8;
    localparam status_t ST_BAD_COUNT   = 4'd9;
    localparam status_t ST_BAD_CHECK   = 4'd10;
    localparam status_t ST_OVERFLOW    = 4'd11;
    localparam status_t ST_TRAILING    = 4'd12;

    localparam logic [1:0] REG_FILLER  = 2'd0;
    localparam logic [1:0] REG_OPCODE  = 2'd1;
    localparam logic [1:0] REG_MAX_LEN = 2'd2;

    localparam logic [7:0]  FILLER_RST  = 8'd1;
    localparam logic [7:0]  OPCODE_RST  = 8'd3;
    localparam logic [10:0] MAX_LEN_RST = 11'd512;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [3:0] KW_LEN      = 4'd5;
    localparam logic [3:0] KW_MISMATCH = 4'd15;

    localparam int FL_NONDIGIT = 0;
    localparam int FL_OVERFLOW = 1;

    typedef struct packed {
        logic [7:0]  filler_opcode;
        logic [7:0]  command_opcode;
        logic [10:0] max_payload_bytes;
    } scfp_cfg_t;

    typedef struct packed {
        logic [7:0] data;
        logic       is_text;
        logic       last;
        status_t    pre_status;
    } scfp_req_t;

    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0: ch = 8'h73;
            3'd1: ch = 8'h70;
            3'd2: ch = 8'h61;
            3'd3: ch = 8'h77;
            3'd4: ch = 8'h6E;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

### rtl/string_command_frame_parser.sv
// String command frame parser.
// Input queue side: one packet byte per request (packet_byte, last_byte),
// taken on push while full is low. Output queue side: one request per
// packet, presented while empty is low and taken on pop.
// Each byte is classified by the front end (framing, length) and passed
// through a two-entry queue to the back end, which tracks tokens and the
// decimal accumulators (one shared multiply-by-ten adder).
// Throughput: one byte per cycle while results are popped; the back end takes
// one queue entry per cycle but stalls on a last byte while a result waits.
// The result is registered as the back end takes its last byte from the queue.
// If the result is not popped, the next packet's bytes keep flowing until
// its last byte reaches the back end; then the queue fills and full rises.
// Reset (rst_n low, async) empties both queues, drops any partial packet
// and loads the configuration defaults: filler 1, opcode 3, length 512.
// Config: APB writes at 0x0 filler, 0x4 opcode, 0x8 length limit; write
// only with no packet in flight.
`default_nettype none

module string_command_frame_parser #(
    parameter int MAX_TOKENS = scfp_pkg::MAX_TOKENS_DEF,
    parameter int VALUE_BITS = scfp_pkg::VALUE_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [7:0]                  packet_byte,
    input  wire logic                        last_byte,
    output logic                             empty,
    input  wire logic                        pop,
    output scfp_pkg::status_t                status,
    output logic [scfp_pkg::VALUE_W-1:0]     count_value,
    output logic [scfp_pkg::VALUE_W-1:0]     checksum_value,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [scfp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [scfp_pkg::REG_W-1:0]  pwdata,
    output logic [scfp_pkg::REG_W-1:0]       prdata,
    output logic                             pready
);
    import scfp_pkg::*;

    scfp_cfg_t cfg_reg;
    scfp_req_t front_req, queue_head;
    logic      in_acc;
    logic      q_nonempty;
    logic      q_take;
    logic      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filler_opcode     <= FILLER_RST;
            cfg_reg.command_opcode    <= OPCODE_RST;
            cfg_reg.max_payload_bytes <= MAX_LEN_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_FILLER:  cfg_reg.filler_opcode     <= pwdata[7:0];
                REG_OPCODE:  cfg_reg.command_opcode    <= pwdata[7:0];
                REG_MAX_LEN: cfg_reg.max_payload_bytes <= pwdata[10:0];
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_FILLER:  prdata = REG_W'(cfg_reg.filler_opcode);
            REG_OPCODE:  prdata = REG_W'(cfg_reg.command_opcode);
            REG_MAX_LEN: prdata = REG_W'(cfg_reg.max_payload_bytes);
            default:     prdata = '0;
        endcase
    end

    assign in_acc = push && !full;

    scfp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .accept      (in_acc),
        .packet_byte (packet_byte),
        .last_byte   (last_byte),
        .req         (front_req)
    );

    scfp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (in_acc),
        .wr_data  (front_req),
        .full     (full),
        .rd_en    (q_take),
        .rd_data  (queue_head),
        .nonempty (q_nonempty)
    );

    scfp_back #(
        .MAX_TOKENS (MAX_TOKENS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (q_nonempty),
        .req            (queue_head),
        .req_take       (q_take),
        .empty          (empty),
        .pop            (pop),
        .status         (status),
        .count_value    (count_value),
        .checksum_value (checksum_value)
    );

endmodule

`default_nettype wire

### rtl/scfp_front.sv
`default_nettype none

module scfp_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire scfp_pkg::scfp_cfg_t cfg,
    input  wire logic               accept,
    input  wire logic [7:0]         packet_byte,
    input  wire logic               last_byte,
    output scfp_pkg::scfp_req_t     req
);
    import scfp_pkg::*;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_TEXT,
        PH_TRAIL
    } phase_t;

    phase_t      phase_reg, phase_next;
    status_t     ferr_reg, ferr_next;
    logic [10:0] cnt_reg, cnt_next;
    logic        is_text;
    status_t     pre_status;

    always_comb
    begin
        cnt_next   = (cnt_reg != '1) ? cnt_reg + 11'd1 : cnt_reg;
        phase_next = phase_reg;
        ferr_next  = ferr_reg;
        is_text    = 1'b0;
        if (ferr_reg == ST_OK)
        begin
            case (phase_reg)
                PH_LEAD:
                begin
                    if (packet_byte == cfg.filler_opcode)
                    begin
                        phase_next = PH_LEAD;
                    end
                    else if (packet_byte == cfg.command_opcode)
                    begin
                        phase_next = PH_TEXT;
                    end
                    else
                    begin
                        ferr_next = ST_BAD_OPCODE;
                    end
                end
                PH_TEXT:
                begin
                    if (packet_byte == CH_NUL)
                    begin
                        phase_next = PH_TRAIL;
                    end
                    else if (packet_byte < CH_SPACE || packet_byte == CH_DEL)
                    begin
                        ferr_next = ST_CONTROL;
                    end
                    else if (packet_byte == CH_SEMI)
                    begin
                        ferr_next = ST_INJECTION;
                    end
                    else
                    begin
                        is_text = 1'b1;
                    end
                end
                PH_TRAIL:
                begin
                    if (packet_byte != cfg.filler_opcode)
                    begin
                        ferr_next = (packet_byte == CH_NUL) ? ST_EMBED_NUL : ST_TRAILING;
                    end
                end
                default:
                begin
                    phase_next = PH_LEAD;
                end
            endcase
        end

        if (cnt_next > cfg.max_payload_bytes)
        begin
            pre_status = ST_TOO_LARGE;
        end
        else if (ferr_next != ST_OK)
        begin
            pre_status = ferr_next;
        end
        else if (phase_next == PH_LEAD)
        begin
            pre_status = ST_BAD_OPCODE;
        end
        else if (phase_next == PH_TEXT)
        begin
            pre_status = ST_NO_TERM;
        end
        else
        begin
            pre_status = ST_OK;
        end
    end

    assign req.data       = packet_byte;
    assign req.is_text    = is_text;
    assign req.last       = last_byte;
    assign req.pre_status = pre_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            ferr_reg  <= ST_OK;
            cnt_reg   <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                phase_reg <= PH_LEAD;
                ferr_reg  <= ST_OK;
                cnt_reg   <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                ferr_reg  <= ferr_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/scfp_queue.sv
`default_nettype none

module scfp_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire scfp_pkg::scfp_req_t wr_data,
    output logic                     full,
    input  wire logic                rd_en,
    output scfp_pkg::scfp_req_t      rd_data,
    output logic                     nonempty
);
    import scfp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    scfp_req_t         mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wptr_reg, rptr_reg;
    logic [CNT_W-1:0]  cnt_reg;

    assign full     = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign rd_data  = mem[rptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wptr_reg <= ptr_inc(wptr_reg);
            end
            if (rd_en)
            begin
                rptr_reg <= ptr_inc(rptr_reg);
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (rd_en && !wr_en)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/scfp_back.sv
`default_nettype none

module scfp_back #(
    parameter int MAX_TOKENS = scfp_pkg::MAX_TOKENS_DEF,
    parameter int VALUE_BITS = scfp_pkg::VALUE_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    input  wire scfp_pkg::scfp_req_t         req,
    output logic                             req_take,
    output logic                             empty,
    input  wire logic                        pop,
    output scfp_pkg::status_t                status,
    output logic [scfp_pkg::VALUE_W-1:0]     count_value,
    output logic [scfp_pkg::VALUE_W-1:0]     checksum_value
);
    import scfp_pkg::*;

    localparam int TN_W = $clog2(MAX_TOKENS + 1);
    localparam int WIDE = VALUE_BITS + 4;

    logic [TN_W-1:0]       tn_reg, tn_next;
    logic                  tle_reg, tle_next;
    logic                  pws_reg, pws_next;
    logic [3:0]            kw_reg, kw_next;
    logic [VALUE_BITS-1:0] cnt_acc_reg, cnt_acc_next;
    logic [1:0]            cnt_fl_reg, cnt_fl_next;
    logic [VALUE_BITS-1:0] chk_acc_reg, chk_acc_next;
    logic [1:0]            chk_fl_reg, chk_fl_next;
    logic                  out_valid_reg;
    status_t               status_reg;
    logic [VALUE_W-1:0]    spawn_reg, check_reg;

    logic                  pop_ok;
    logic                  feed_en;
    logic [TN_W-1:0]       feed_tok;
    logic [7:0]            ch;
    logic                  is_digit;
    logic [VALUE_BITS-1:0] acc_sel;
    logic [1:0]            fl_sel, fl_new;
    logic [WIDE-1:0]       prod;
    logic [VALUE_BITS-1:0] acc_new;
    status_t               fin_status;

    assign pop_ok   = pop && !out_valid_reg ? 1'b0 : (pop && out_valid_reg);
    assign req_take = req_valid && (!req.last || !out_valid_reg || pop_ok);
    assign ch       = req.data;
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);

    always_comb
    begin
        feed_en  = 1'b0;
        feed_tok = tn_reg;
        pws_next = pws_reg;
        tn_next  = tn_reg;
        tle_next = tle_reg;
        if (req.is_text && !tle_reg)
        begin
            if (pws_reg)
            begin
                if (ch == CH_SPACE || tn_reg >= TN_W'(MAX_TOKENS))
                begin
                    tle_next = 1'b1;
                end
                else
                begin
                    tn_next  = tn_reg + TN_W'(1);
                    pws_next = 1'b0;
                    feed_en  = 1'b1;
                    feed_tok = tn_reg + TN_W'(1);
                end
            end
            else if (ch == CH_SPACE)
            begin
                pws_next = 1'b1;
            end
            else
            begin
                feed_en = 1'b1;
            end
        end
    end

    // one multiply-by-ten unit shared by both numeric tokens
    always_comb
    begin
        acc_sel = (feed_tok == TN_W'(2)) ? cnt_acc_reg : chk_acc_reg;
        fl_sel  = (feed_tok == TN_W'(2)) ? cnt_fl_reg : chk_fl_reg;
        prod    = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0}
                + WIDE'(ch[3:0]);
        acc_new = acc_sel;
        fl_new  = fl_sel;
        if (!is_digit)
        begin
            fl_new[FL_NONDIGIT] = 1'b1;
        end
        else if (!fl_sel[FL_OVERFLOW])
        begin
            if (prod[WIDE-1:VALUE_BITS] != '0)
            begin
                fl_new[FL_OVERFLOW] = 1'b1;
            end
            else
            begin
                acc_new = prod[VALUE_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        kw_next      = kw_reg;
        cnt_acc_next = cnt_acc_reg;
        cnt_fl_next  = cnt_fl_reg;
        chk_acc_next = chk_acc_reg;
        chk_fl_next  = chk_fl_reg;
        if (feed_en)
        begin
            if (feed_tok == TN_W'(1))
            begin
                if (kw_reg < KW_LEN && ch == kw_char(kw_reg[2:0]))
                begin
                    kw_next = kw_reg + 4'd1;
                end
                else
                begin
                    kw_next = KW_MISMATCH;
                end
            end
            else if (feed_tok == TN_W'(2))
            begin
                cnt_acc_next = acc_new;
                cnt_fl_next  = fl_new;
            end
            else if (feed_tok == TN_W'(3))
            begin
                chk_acc_next = acc_new;
                chk_fl_next  = fl_new;
            end
        end
    end

    always_comb
    begin
        if (req.pre_status != ST_OK)
        begin
            fin_status = req.pre_status;
        end
        else if (tle_reg)
        begin
            fin_status = ST_ARG_COUNT;
        end
        else if (tn_reg == '0 || kw_reg != KW_LEN)
        begin
            fin_status = ST_UNSUPPORTED;
        end
        else if (tn_reg != TN_W'(3))
        begin
            fin_status = ST_ARG_COUNT;
        end
        else if (cnt_fl_reg[FL_NONDIGIT])
        begin
            fin_status = ST_BAD_COUNT;
        end
        else if (cnt_fl_reg[FL_OVERFLOW])
        begin
            fin_status = ST_OVERFLOW;
        end
        else if (chk_fl_reg[FL_NONDIGIT])
        begin
            fin_status = ST_BAD_CHECK;
        end
        else if (chk_fl_reg[FL_OVERFLOW])
        begin
            fin_status = ST_OVERFLOW;
        end
        else
        begin
            fin_status = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tn_reg        <= '0;
            tle_reg       <= 1'b0;
            pws_reg       <= 1'b1;
            kw_reg        <= '0;
            cnt_acc_reg   <= '0;
            cnt_fl_reg    <= '0;
            chk_acc_reg   <= '0;
            chk_fl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop_ok && !(req_take && req.last))
            begin
                out_valid_reg <= 1'b0;
            end
            if (req_take)
            begin
                if (req.last)
                begin
                    tn_reg        <= '0;
                    tle_reg       <= 1'b0;
                    pws_reg       <= 1'b1;
                    kw_reg        <= '0;
                    cnt_acc_reg   <= '0;
                    cnt_fl_reg    <= '0;
                    chk_acc_reg   <= '0;
                    chk_fl_reg    <= '0;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    tn_reg      <= tn_next;
                    tle_reg     <= tle_next;
                    pws_reg     <= pws_next;
                    kw_reg      <= kw_next;
                    cnt_acc_reg <= cnt_acc_next;
                    cnt_fl_reg  <= cnt_fl_next;
                    chk_acc_reg <= chk_acc_next;
                    chk_fl_reg  <= chk_fl_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take && req.last)
        begin
            status_reg <= fin_status;
            spawn_reg  <= (fin_status == ST_OK) ? VALUE_W'(cnt_acc_reg) : '0;
            check_reg  <= (fin_status == ST_OK) ? VALUE_W'(chk_acc_reg) : '0;
        end
    end

    assign empty          = !out_valid_reg;
    assign status         = status_reg;
    assign count_value    = spawn_reg;
    assign checksum_value = check_reg;

endmodule

`default_nettype wire
